FILE: hw/rtl/yuv420_marker_box_overlay_assert.svh
// Assertion macros shared by the overlay checker.
`ifndef YUV420_MARKER_BOX_OVERLAY_ASSERT_SVH
`define YUV420_MARKER_BOX_OVERLAY_ASSERT_SVH

// Checked only outside reset.
`define YMB_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define YMB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ymb_pkg.sv
// Shared types, codes and box functions of the marker box overlay.
package ymb_pkg;

  localparam int MARKER_SLOTS = 16;
  localparam int BOX_HALF     = 5;
  localparam int SLOT_W       = (MARKER_SLOTS > 1) ? $clog2(MARKER_SLOTS) : 1;

  localparam logic [2:0] CMD_MOVE      = 3'd0;
  localparam logic [2:0] CMD_PRESS     = 3'd1;
  localparam logic [2:0] CMD_RELEASE   = 3'd2;
  localparam logic [2:0] CMD_FRAME_END = 3'd3;
  localparam logic [2:0] CMD_PIXEL     = 3'd4;

  localparam logic [1:0] PLANE_Y      = 2'd0;
  localparam logic [1:0] PLANE_U      = 2'd1;
  localparam logic [1:0] PLANE_V      = 2'd2;
  localparam logic [1:0] PLANE_UNUSED = 2'd3;

  localparam logic [1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_MARKER_LIFETIME = 2'd2;

  localparam logic [7:0] PRESS_Y      = 8'd150;
  localparam logic [7:0] PRESS_U      = 8'd46;
  localparam logic [7:0] PRESS_V      = 8'd21;
  localparam logic [7:0] RELEASE_Y    = 8'd76;
  localparam logic [7:0] RELEASE_U    = 8'd85;
  localparam logic [7:0] RELEASE_V    = 8'd255;
  localparam logic [7:0] POINTER_LUMA = 8'd0;
  localparam logic [7:0] POINTER_C    = 8'd128;

  localparam logic signed [13:0] BOX_HALF_S = 14'(BOX_HALF);

  typedef struct packed {
    logic                    vld;
    logic [2:0]              cmd;
    logic signed [12:0]      px;
    logic signed [12:0]      py;
    logic [1:0]              plane;
    logic [11:0]             col;
    logic [11:0]             line;
    logic [7:0]              pix;
    logic [SLOT_W-1:0]       slot;
    logic [7:0]              life;
    logic                    ptr_hit;
    logic                    found;
    logic [SLOT_W-1:0]       rank;
    logic                    best_rel;
  } tok_t;

  function automatic logic box_covers(input logic signed [12:0] px,
                                      input logic signed [12:0] py,
                                      input logic [1:0] plane,
                                      input logic [11:0] col,
                                      input logic [11:0] line,
                                      input logic [12:0] w,
                                      input logic [12:0] h);
    logic signed [13:0] pxe;
    logic signed [13:0] pye;
    logic signed [13:0] we;
    logic signed [13:0] he;
    logic signed [13:0] x1;
    logic signed [13:0] x2;
    logic signed [13:0] y1;
    logic signed [13:0] y2;
    logic signed [13:0] ce;
    logic signed [13:0] le;
    logic               in_frame;
    pxe = {px[12], px};
    pye = {py[12], py};
    we  = $signed({1'b0, w});
    he  = $signed({1'b0, h});
    ce  = $signed({2'b00, col});
    le  = $signed({2'b00, line});
    in_frame = !px[12] && !py[12] && (pxe < we) && (pye < he) && (plane != PLANE_UNUSED);
    x1 = pxe - BOX_HALF_S;
    if (x1 < 0) x1 = '0;
    x2 = pxe + BOX_HALF_S;
    if (x2 > we) x2 = we;
    y1 = pye - BOX_HALF_S;
    if (y1 < 0) y1 = '0;
    y2 = pye + BOX_HALF_S;
    if (y2 > he) y2 = he;
    if (plane != PLANE_Y) begin
      x1 = x1 >>> 1;
      x2 = x2 >>> 1;
      y1 = y1 >>> 1;
      y2 = y2 >>> 1;
    end
    return in_frame && (ce >= x1) && (ce < x2) && (le >= y1) && (le < y2);
  endfunction

  function automatic logic [7:0] plane_colour(input logic rel, input logic [1:0] plane);
    logic [7:0] c;
    unique case (plane)
      PLANE_Y: c = rel ? RELEASE_Y : PRESS_Y;
      PLANE_U: c = rel ? RELEASE_U : PRESS_U;
      default: c = rel ? RELEASE_V : PRESS_V;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/ymb_entry.sv
// Entry stage: pointer position, ring insert slot and pointer box test.
module ymb_entry (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [2:0]         in_cmd,
  input  logic signed [12:0] in_pos_x,
  input  logic signed [12:0] in_pos_y,
  input  logic [1:0]         in_plane,
  input  logic [11:0]        in_column,
  input  logic [11:0]        in_line,
  input  logic [7:0]         in_pixel_in,
  input  logic [12:0]        frame_width,
  input  logic [12:0]        frame_height,
  input  logic [7:0]         marker_lifetime,
  output ymb_pkg::tok_t      tok_o
);
  import ymb_pkg::*;

  logic signed [12:0] ptr_col_r;
  logic signed [12:0] ptr_col_nxt;
  logic signed [12:0] ptr_row_r;
  logic signed [12:0] ptr_row_nxt;
  logic [SLOT_W-1:0]  ins_r;
  logic [SLOT_W-1:0]  ins_nxt;
  tok_t               tok_r;
  tok_t               tok_nxt;
  logic               acc;

  assign acc = in_valid && adv;

  always_comb begin
    ptr_col_nxt = ptr_col_r;
    ptr_row_nxt = ptr_row_r;
    ins_nxt     = ins_r;
    if (acc && in_cmd == CMD_MOVE) begin
      ptr_col_nxt = in_pos_x;
      ptr_row_nxt = in_pos_y;
    end
    if (acc && (in_cmd == CMD_PRESS || in_cmd == CMD_RELEASE)) begin
      ins_nxt = (ins_r == SLOT_W'(MARKER_SLOTS - 1)) ? '0 : ins_r + 1'b1;
    end
    tok_nxt          = '0;
    tok_nxt.vld      = acc;
    tok_nxt.cmd      = in_cmd;
    tok_nxt.px       = in_pos_x;
    tok_nxt.py       = in_pos_y;
    tok_nxt.plane    = in_plane;
    tok_nxt.col      = in_column;
    tok_nxt.line     = in_line;
    tok_nxt.pix      = in_pixel_in;
    tok_nxt.slot     = ins_r;
    tok_nxt.life     = marker_lifetime;
    tok_nxt.ptr_hit  = box_covers(ptr_col_r, ptr_row_r, in_plane, in_column, in_line,
                                  frame_width, frame_height);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_col_r <= '1;
      ptr_row_r <= '1;
      ins_r     <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      ptr_col_r <= ptr_col_nxt;
      ptr_row_r <= ptr_row_nxt;
      ins_r     <= ins_nxt;
      if (adv) begin
        tok_r <= tok_nxt;
      end
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: hw/rtl/ymb_cell.sv
// One marker slot of the chain: holds a marker, applies commands and tests pixels.
module ymb_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [ymb_pkg::SLOT_W-1:0] cell_idx,
  input  logic [12:0]               frame_width,
  input  logic [12:0]               frame_height,
  input  ymb_pkg::tok_t             tok_i,
  output ymb_pkg::tok_t             tok_o
);
  import ymb_pkg::*;

  logic signed [12:0] mcol_r;
  logic signed [12:0] mrow_r;
  logic               rel_r;
  logic [7:0]         left_r;
  logic [7:0]         left_nxt;
  tok_t               tok_r;
  tok_t               tok_nxt;
  logic               wr;
  logic               hit;
  logic [SLOT_W:0]    diff;
  logic [SLOT_W-1:0]  rank;

  assign wr = tok_i.vld && (tok_i.cmd == CMD_PRESS || tok_i.cmd == CMD_RELEASE) &&
              (tok_i.slot == cell_idx);

  always_comb begin
    left_nxt = left_r;
    if (wr) begin
      left_nxt = tok_i.life;
    end else if (tok_i.vld && tok_i.cmd == CMD_FRAME_END && left_r != '0) begin
      left_nxt = left_r - 1'b1;
    end
    hit  = (left_r != '0) &&
           box_covers(mcol_r, mrow_r, tok_i.plane, tok_i.col, tok_i.line,
                      frame_width, frame_height);
    diff = {1'b0, cell_idx} - {1'b0, tok_i.slot};
    if (cell_idx < tok_i.slot) begin
      diff = diff + (SLOT_W + 1)'(MARKER_SLOTS);
    end
    rank    = diff[SLOT_W-1:0];
    tok_nxt = tok_i;
    if (tok_i.cmd == CMD_PIXEL && hit && (!tok_i.found || rank < tok_i.rank)) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.rank     = rank;
      tok_nxt.best_rel = rel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r    <= '0;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      left_r <= left_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr) begin
      mcol_r <= tok_i.px;
      mrow_r <= tok_i.py;
      rel_r  <= (tok_i.cmd == CMD_RELEASE);
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: hw/rtl/yuv420_marker_box_overlay.sv
// Top level of the 4:2:0 marker and pointer box overlay.
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_ready | cmd, pos_x, pos_y, plane, column, line, pixel_in
//   out     | output    | out_valid/out_ready | pixel_out
//   cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// One transaction enters per cycle while in_ready is high; a pixel result passes the entry
// register and then one register in each of the MARKER_SLOTS (16) marker slot cells.
// Commands travel down the same chain, so each slot sees them in order with the pixels.
// Reset is synchronous, sets the pointer off frame (all ones) and clears the ring slot and every marker's lifetime.
// While a result waits with out_ready low, the whole chain holds and in_ready stays low.
module yuv420_marker_box_overlay (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic signed [12:0] in_pos_x,
  input  logic signed [12:0] in_pos_y,
  input  logic [1:0]         in_plane,
  input  logic [11:0]        in_column,
  input  logic [11:0]        in_line,
  input  logic [7:0]         in_pixel_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_pixel_out,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import ymb_pkg::*;

  logic [12:0] frame_width_r;
  logic [12:0] frame_height_r;
  logic [7:0]  lifetime_r;
  logic        adv;
  tok_t        chain [MARKER_SLOTS+1];
  tok_t        last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 13'd640;
      frame_height_r <= 13'd480;
      lifetime_r     <= 8'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:     frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT:    frame_height_r <= cfg_data;
        REG_MARKER_LIFETIME: lifetime_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign last      = chain[MARKER_SLOTS];
  assign out_valid = last.vld && (last.cmd == CMD_PIXEL);
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  ymb_entry u_entry (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_valid),
    .in_cmd          (in_cmd),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_plane        (in_plane),
    .in_column       (in_column),
    .in_line         (in_line),
    .in_pixel_in     (in_pixel_in),
    .frame_width     (frame_width_r),
    .frame_height    (frame_height_r),
    .marker_lifetime (lifetime_r),
    .tok_o           (chain[0])
  );

  for (genvar g = 0; g < MARKER_SLOTS; g++) begin : g_cell
    ymb_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .adv          (adv),
      .cell_idx     (SLOT_W'(g)),
      .frame_width  (frame_width_r),
      .frame_height (frame_height_r),
      .tok_i        (chain[g]),
      .tok_o        (chain[g+1])
    );
  end

  always_comb begin
    if (last.ptr_hit) begin
      out_pixel_out = (last.plane == PLANE_Y) ? POINTER_LUMA : POINTER_C;
    end else if (last.found) begin
      out_pixel_out = plane_colour(last.best_rel, last.plane);
    end else begin
      out_pixel_out = last.pix;
    end
  end

endmodule

FILE: hw/rtl/ymb_checker.sv
// Port-level checker for the overlay and its bind to the top level.
`include "yuv420_marker_box_overlay_assert.svh"

module ymb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         out_pixel_out
);

  logic stall;

  assign stall = out_valid && !out_ready;

  `YMB_ASSERT_RUN(a_out_hold, stall |=> out_valid && $stable(out_pixel_out), "held result changed")
  `YMB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result shown right after reset")
  `YMB_ASSERT_RUN(a_ready_free, !stall |-> in_ready, "input held without a stall")

endmodule

bind yuv420_marker_box_overlay ymb_checker u_ymb_checker (.*);

FILE: dv/yuv420_marker_box_overlay_checker.sv
`timescale 1ns / 100ps
// Checker for the marker box overlay: tracks pointer and markers, predicts and compares pixels.
module yuv420_marker_box_overlay_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic signed [12:0] in_pos_x,
  input  logic signed [12:0] in_pos_y,
  input  logic [1:0]         in_plane,
  input  logic [11:0]        in_column,
  input  logic [11:0]        in_line,
  input  logic [7:0]         in_pixel_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         out_pixel_out,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 checked
);
  import ymb_pkg::*;

  int         frame_w;
  int         frame_h;
  int         lifetime;
  int         ptr_x;
  int         ptr_y;
  int         mark_x [MARKER_SLOTS];
  int         mark_y [MARKER_SLOTS];
  int         mark_left [MARKER_SLOTS];
  bit         mark_rel [MARKER_SLOTS];
  int         next_slot;
  logic [7:0] overlay_pixels [$];
  logic [7:0] want;

  function automatic bit in_box(int px, int py, logic [1:0] pl, int c, int r);
    int x1;
    int x2;
    int y1;
    int y2;
    if (px < 0 || py < 0 || px >= frame_w || py >= frame_h) return 1'b0;
    x1 = (px > BOX_HALF) ? px - BOX_HALF : 0;
    x2 = (px + BOX_HALF < frame_w) ? px + BOX_HALF : frame_w;
    y1 = (py > BOX_HALF) ? py - BOX_HALF : 0;
    y2 = (py + BOX_HALF < frame_h) ? py + BOX_HALF : frame_h;
    if (pl != PLANE_Y) begin
      x1 = x1 / 2;
      x2 = x2 / 2;
      y1 = y1 / 2;
      y2 = y2 / 2;
    end
    return c >= x1 && c < x2 && r >= y1 && r < y2;
  endfunction

  function automatic logic [7:0] marker_shade(bit rel, logic [1:0] pl);
    case (pl)
      PLANE_Y: return rel ? RELEASE_Y : PRESS_Y;
      PLANE_U: return rel ? RELEASE_U : PRESS_U;
      default: return rel ? RELEASE_V : PRESS_V;
    endcase
  endfunction

  // The pointer sits on top; among markers the least recently written slot wins.
  function automatic logic [7:0] overlay_pixel(logic [1:0] pl, int c, int r, logic [7:0] src);
    int k;
    if (pl == PLANE_UNUSED) return src;
    if (in_box(ptr_x, ptr_y, pl, c, r)) return (pl == PLANE_Y) ? POINTER_LUMA : POINTER_C;
    for (int i = 0; i < MARKER_SLOTS; i++) begin
      k = (next_slot + i) % MARKER_SLOTS;
      if (mark_left[k] != 0 && in_box(mark_x[k], mark_y[k], pl, c, r))
        return marker_shade(mark_rel[k], pl);
    end
    return src;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_w = 640;
      frame_h = 480;
      lifetime = 30;
      ptr_x = -1;
      ptr_y = -1;
      next_slot = 0;
      for (int i = 0; i < MARKER_SLOTS; i++) begin
        mark_x[i] = 0;
        mark_y[i] = 0;
        mark_left[i] = 0;
        mark_rel[i] = 1'b0;
      end
      overlay_pixels.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:     frame_w = int'(cfg_data);
          REG_FRAME_HEIGHT:    frame_h = int'(cfg_data);
          REG_MARKER_LIFETIME: lifetime = int'(cfg_data[7:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_cmd)
          CMD_MOVE: begin
            ptr_x = in_pos_x;
            ptr_y = in_pos_y;
          end
          CMD_PRESS, CMD_RELEASE: begin
            mark_x[next_slot] = in_pos_x;
            mark_y[next_slot] = in_pos_y;
            mark_rel[next_slot] = (in_cmd == CMD_RELEASE);
            mark_left[next_slot] = lifetime;
            next_slot = (next_slot + 1) % MARKER_SLOTS;
          end
          CMD_FRAME_END: begin
            for (int i = 0; i < MARKER_SLOTS; i++)
              if (mark_left[i] != 0) mark_left[i]--;
          end
          CMD_PIXEL:
            overlay_pixels.push_back(overlay_pixel(in_plane, in_column, in_line, in_pixel_in));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (overlay_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel transaction, expected none, actual %0d",
                   $time, out_pixel_out);
        end else begin
          want = overlay_pixels.pop_front();
          checked++;
          if (out_pixel_out !== want) begin
            errors++;
            $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                     $time, want, out_pixel_out);
          end
        end
      end
    end
    pending = overlay_pixels.size();
  end

endmodule

FILE: dv/yuv420_marker_box_overlay_tb.sv
`timescale 1ns / 100ps
// Testbench top for the marker box overlay: clock, reset, stimulus, back-pressure and verdict.
module yuv420_marker_box_overlay_tb;
  import ymb_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int IDLE_RX_HEAVY = 0;
  localparam int IDLE_TX_HEAVY = 1;
  localparam int IDLE_NONE     = 2;
  localparam int HALF_PERIOD   = 4;
  localparam int PIPE_CYCLES   = MARKER_SLOTS + 1;
  localparam int SETTLE_CYCLES = 3 * PIPE_CYCLES;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASES        = 6;
  localparam int HOLD_PHASE    = 4;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_cmd = CMD_MOVE;
  logic signed [12:0] in_pos_x = '0;
  logic signed [12:0] in_pos_y = '0;
  logic [1:0]         in_plane = PLANE_Y;
  logic [11:0]        in_column = '0;
  logic [11:0]        in_line = '0;
  logic [7:0]         in_pixel_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_pixel_out;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_FRAME_WIDTH;
  logic [12:0]        cfg_data = '0;

  int errors;
  int pending;
  int checked;
  int sent = 0;
  int cur_w = 640;
  int cur_h = 480;
  int idle_mode = IDLE_RX_HEAVY;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int ph_w [PHASES]     = '{2, 4096, 21, 0, 32, 640};
  int ph_h [PHASES]     = '{2, 4096, 15, 4096, 24, 480};
  int ph_life [PHASES]  = '{1, 255, 2, 0, 4, 30};
  int ph_items [PHASES] = '{70, 80, 80, 30, 90, 80};
  int ph_mode [PHASES]  = '{IDLE_RX_HEAVY, IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_TX_HEAVY,
                            IDLE_NONE, IDLE_NONE};

  always #HALF_PERIOD clk = ~clk;

  yuv420_marker_box_overlay DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_plane      (in_plane),
    .in_column     (in_column),
    .in_line       (in_line),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  yuv420_marker_box_overlay_checker overlay_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_plane      (in_plane),
    .in_column     (in_column),
    .in_line       (in_line),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked)
  );

  function automatic int idle_pct(int mode, bit receiver);
    case (mode)
      IDLE_RX_HEAVY: return receiver ? 86 : 8;
      IDLE_TX_HEAVY: return receiver ? 8 : 86;
      default:       return 0;
    endcase
  endfunction

  // The receiver takes one long hold-off on request so that the pipeline fills up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct(idle_mode, 1'b1));
    end
  end

  function automatic int pick_point(int dim);
    int r;
    r = $urandom_range(99);
    if (dim <= 0 || r < 8) return int'($signed(13'($urandom)));
    if (r < 20) return dim - 1 - int'($urandom_range(BOX_HALF + 1));
    if (r < 26) return dim + int'($urandom_range(BOX_HALF));
    return int'($urandom_range((dim < 40 ? dim : 40) - 1));
  endfunction

  function automatic int pick_sample(int dim, int hot);
    int r;
    int k;
    r = $urandom_range(99);
    if (dim <= 0 || r < 8) return int'($urandom_range(4095));
    if (r < 20) begin
      k = dim - 1 - int'($urandom_range(BOX_HALF + 1));
      return (k < 0) ? 0 : k;
    end
    return int'($urandom_range((dim < hot ? dim : hot) - 1));
  endfunction

  task automatic send(logic [2:0] cmd, int x, int y, logic [1:0] pl, int c, int r,
                      logic [7:0] pix);
    while ($urandom_range(99) < idle_pct(idle_mode, 1'b0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_pos_x <= 13'(x);
    in_pos_y <= 13'(y);
    in_plane <= pl;
    in_column <= 12'(c);
    in_line <= 12'(r);
    in_pixel_in <= pix;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic random_item();
    int r;
    int dim_x;
    int dim_y;
    int hot;
    logic [1:0] pl;
    logic [2:0] cmd;
    r = $urandom_range(99);
    if (r < 45) cmd = CMD_PIXEL;
    else if (r < 60) cmd = CMD_MOVE;
    else if (r < 72) cmd = CMD_PRESS;
    else if (r < 84) cmd = CMD_RELEASE;
    else if (r < 95) cmd = CMD_FRAME_END;
    else cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    pl = ($urandom_range(19) == 0) ? PLANE_UNUSED : 2'($urandom_range(PLANE_V, PLANE_Y));
    if (pl == PLANE_Y) begin
      dim_x = cur_w;
      dim_y = cur_h;
      hot = 40;
    end else begin
      dim_x = cur_w / 2 + 1;
      dim_y = cur_h / 2 + 1;
      hot = 20;
    end
    send(cmd, pick_point(cur_w), pick_point(cur_h), pl, pick_sample(dim_x, hot),
         pick_sample(dim_y, hot), 8'($urandom));
  endtask

  task automatic program_frame(int w, int h, int life);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= 13'(w);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= 13'(h);
    @(posedge clk);
    cfg_index <= REG_MARKER_LIFETIME;
    cfg_data <= 13'(life);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    program_frame(16, 12, 2);

    send(CMD_PIXEL, 0, 0, PLANE_Y, 0, 0, 8'd0);
    send(CMD_MOVE, -4096, 4095, PLANE_Y, 0, 0, 8'd0);
    send(CMD_PIXEL, 0, 0, PLANE_V, 4095, 4095, 8'd255);
    send(CMD_PRESS, 0, 0, PLANE_Y, 0, 0, 8'd0);
    send(CMD_RELEASE, 15, 11, PLANE_Y, 0, 0, 8'd0);
    send(CMD_PRESS, 16, 5, PLANE_Y, 0, 0, 8'd0);
    send(CMD_RELEASE, 3, 3, PLANE_Y, 0, 0, 8'd0);
    send(CMD_PIXEL, 0, 0, PLANE_Y, 2, 2, 8'd77);
    send(CMD_PIXEL, 0, 0, PLANE_Y, 15, 11, 8'd77);
    send(CMD_PIXEL, 0, 0, PLANE_U, 7, 5, 8'd77);
    send(CMD_PIXEL, 0, 0, PLANE_V, 1, 1, 8'd77);
    send(CMD_PIXEL, 0, 0, PLANE_Y, 15, 5, 8'd77);
    send(CMD_MOVE, 4, 4, PLANE_Y, 0, 0, 8'd0);
    send(CMD_PIXEL, 0, 0, PLANE_Y, 2, 2, 8'd99);
    send(CMD_PIXEL, 0, 0, PLANE_U, 1, 1, 8'd99);
    send(CMD_PIXEL, 0, 0, PLANE_UNUSED, 2, 2, 8'd200);
    send(CMD_SPARE_LO, 5, 5, PLANE_Y, 0, 0, 8'd0);
    send(CMD_SPARE_LO + 3'd1, 5, 5, PLANE_Y, 0, 0, 8'd0);
    send(CMD_SPARE_HI, 5, 5, PLANE_Y, 0, 0, 8'd0);
    send(CMD_PIXEL, 0, 0, PLANE_Y, 5, 5, 8'd99);
    send(CMD_FRAME_END, 0, 0, PLANE_Y, 0, 0, 8'd0);
    send(CMD_FRAME_END, 0, 0, PLANE_Y, 0, 0, 8'd0);
    send(CMD_MOVE, 4095, -4096, PLANE_Y, 0, 0, 8'd0);
    send(CMD_PIXEL, 0, 0, PLANE_Y, 0, 0, 8'd255);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      program_frame(ph_w[p], ph_h[p], ph_life[p]);
      idle_mode <= ph_mode[p];
      if (p == HOLD_PHASE) hold_req <= 1'b1;
      repeat (ph_items[p]) random_item();
    end
    settle();

    $display("Sent %0d transactions over %0d frame settings, from empty to 4096x4096 frames.",
             sent, PHASES + 1);
    $display("Compared %0d overlay pixels with %0d mismatches.", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
